// File: rtl/core/tfic_pkg.sv
package tfic_pkg;
  localparam int MaxVertices = 11;
  localparam int EdgeBits = 55;
  localparam int CntW = 4;
  localparam int DepthW = 4;

  typedef logic [MaxVertices-1:0] vset_t;
  typedef vset_t [MaxVertices-1:0] adj_t;

  // classified graph handed from front to back
  typedef struct packed {
    adj_t adj;
    logic [CntW-1:0] n;
    logic pad;
  } job_t;

  typedef struct packed {
    logic verdict;
    logic triangle_found;
    logic independent_found;
    logic padding_error;
  } res_t;

  // pair count n*(n-1)/2 for n in 0..11; any larger n gives 55
  function automatic logic [5:0] pair_count(input logic [CntW-1:0] n);
    logic [5:0] r;
    case (n)
      4'd0, 4'd1: r = 6'd0;
      4'd2: r = 6'd1;
      4'd3: r = 6'd3;
      4'd4: r = 6'd6;
      4'd5: r = 6'd10;
      4'd6: r = 6'd15;
      4'd7: r = 6'd21;
      4'd8: r = 6'd28;
      4'd9: r = 6'd36;
      4'd10: r = 6'd45;
      default: r = 6'd55;
    endcase
    return r;
  endfunction
endpackage

// File: rtl/core/tfic_if.sv
interface tfic_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [3:0] vertex_count;
  logic [54:0] edge_word;
  modport source (output valid, vertex_count, edge_word, input ready);
  modport sink (input valid, vertex_count, edge_word, output ready);
endinterface

interface tfic_out_if (input logic clk);
  logic valid;
  logic ready;
  logic verdict;
  logic triangle_found;
  logic independent_found;
  logic padding_error;
  modport source (output valid, verdict, triangle_found, independent_found, padding_error,
                  input ready);
  modport sink (input valid, verdict, triangle_found, independent_found, padding_error,
                output ready);
endinterface

interface tfic_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/triangle_free_independence_check.sv
// channel    dir  width  word
// in_ch      in   59     vertex_count, edge_word
// out_ch     out  4      verdict, triangle_found, independent_found, padding_error
// cfg_ch     in   4      independence_bound
// A word passes the front register and the queue, then a triangle scan over the vertex rows
// and a backtracking search in the back part, then the output register.
// Rate is set by the single search sequencer in the back part.
// rst is synchronous and clears all handshakes; the bound returns to 3.
// The front keeps accepting into a two-word queue while the back is busy.
module triangle_free_independence_check (
  input logic clk,
  input logic rst,
  tfic_in_if.sink in_ch,
  tfic_out_if.source out_ch,
  tfic_cfg_if.sink cfg_ch
);
  logic [3:0] bound;
  logic fv, fr, bv, br;
  tfic_pkg::job_t fj, bj;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bound <= 4'd3;
    else if (cfg_ch.valid) bound <= cfg_ch.data;
  end

  tfic_front u_front (.clk, .rst, .in_ch, .job_valid(fv), .job_ready(fr), .job(fj));
  tfic_queue u_queue (.clk, .rst, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
                      .rd_valid(bv), .rd_ready(br), .rd_data(bj));
  tfic_back u_back (.clk, .rst, .bound, .job_valid(bv), .job_ready(br), .job(bj), .out_ch);
endmodule

// File: rtl/core/tfic_front.sv
module tfic_front (
  input  logic clk,
  input  logic rst,
  tfic_in_if.sink in_ch,
  output logic job_valid,
  input  logic job_ready,
  output tfic_pkg::job_t job
);
  // one-pass rebuild of adjacency rows from the packed pair bits
  tfic_pkg::job_t job_next;
  logic [3:0] n;
  logic [5:0] pc;
  logic [54:0] mask;

  always_comb begin
    int pos;
    n = (in_ch.vertex_count > 4'(tfic_pkg::MaxVertices)) ?
        4'(tfic_pkg::MaxVertices) : in_ch.vertex_count;
    pc = tfic_pkg::pair_count(n);
    mask = ~((55'd1 << pc) - 55'd1);
    job_next.n = n;
    job_next.pad = |(in_ch.edge_word & mask);
    job_next.adj = '0;
    pos = 0;
    for (int u = 0; u < tfic_pkg::MaxVertices; u++) begin
      for (int v = u + 1; v < tfic_pkg::MaxVertices; v++) begin
        if (v < int'(n) && in_ch.edge_word[pos]) begin
          job_next.adj[u][v] = 1'b1;
          job_next.adj[v][u] = 1'b1;
        end
        if (v < int'(n)) pos++;
      end
    end
  end

  assign in_ch.ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ch.ready) begin
      job_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) job <= job_next;
  end
endmodule

// File: rtl/core/tfic_queue.sv
module tfic_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  tfic_pkg::job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output tfic_pkg::job_t rd_data
);
  // two-entry queue
  tfic_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end
endmodule

// File: rtl/core/tfic_back.sv
module tfic_back (
  input  logic clk,
  input  logic rst,
  input  logic [3:0] bound,
  input  logic job_valid,
  output logic job_ready,
  input  tfic_pkg::job_t job,
  tfic_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TRI  = 4'b0010,
    S_SRCH = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  tfic_pkg::job_t cur;
  logic [3:0] tv;
  logic tri_f;
  logic ind_f;
  logic row_tri;
  // search stack: candidate set per depth; need holds the count still to choose
  tfic_pkg::vset_t cand [tfic_pkg::MaxVertices+1];
  logic [3:0] depth;
  logic [4:0] need;
  logic [3:0] lo;
  tfic_pkg::vset_t c, rest;
  logic [3:0] pop;

  always_comb begin
    c = cand[depth];
    lo = 4'd0;
    for (int i = tfic_pkg::MaxVertices - 1; i >= 0; i--) if (c[i]) lo = 4'(i);
    rest = c & (c - 1'b1);
    pop = '0;
    for (int i = 0; i < tfic_pkg::MaxVertices; i++) pop = pop + 4'(c[i]);
    // edge tv-v with a common neighbor
    row_tri = 1'b0;
    for (int v = 0; v < tfic_pkg::MaxVertices; v++)
      if (cur.adj[tv][v] && |(cur.adj[tv] & cur.adj[v])) row_tri = 1'b1;
  end

  assign job_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (job_valid) begin
          cur <= job;
          tv <= 4'd0;
          tri_f <= 1'b0;
          state <= S_TRI;
        end
        S_TRI: begin
          // one vertex row per cycle
          if (row_tri) tri_f <= 1'b1;
          if (tv == 4'(tfic_pkg::MaxVertices - 1)) begin
            state <= S_SRCH;
            depth <= 4'd0;
            cand[0] <= tfic_pkg::vset_t'((12'd1 << cur.n) - 12'd1);
            need <= 5'(bound) + 5'd1;
          end
          tv <= tv + 4'd1;
        end
        S_SRCH: begin
          // one backtracking step per cycle
          if (need == 5'd0) begin
            ind_f <= 1'b1;
            state <= S_DONE;
          end else if (5'(pop) < need) begin
            if (depth == 4'd0) begin
              ind_f <= 1'b0;
              state <= S_DONE;
            end else begin
              depth <= depth - 4'd1;
              need <= need + 5'd1;
            end
          end else begin
            cand[depth] <= rest;
            cand[depth + 4'd1] <= rest & ~cur.adj[lo];
            depth <= depth + 4'd1;
            need <= need - 5'd1;
          end
        end
        S_DONE: if (!out_ch.valid || out_ch.ready) begin
          out_ch.triangle_found <= tri_f;
          out_ch.independent_found <= ind_f;
          out_ch.padding_error <= cur.pad;
          out_ch.verdict <= !tri_f && !ind_f && !cur.pad;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/tfic_checker.sv
module tfic_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic verdict,
  input logic triangle_found,
  input logic independent_found,
  input logic padding_error
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict == !(triangle_found || independent_found || padding_error))
    else $error("verdict mismatch");
  a_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict |-> !padding_error) else $error("pass with padding");
endmodule

bind triangle_free_independence_check tfic_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .verdict(out_ch.verdict), .triangle_found(out_ch.triangle_found),
  .independent_found(out_ch.independent_found), .padding_error(out_ch.padding_error));
